FILE: design/bcbn_pkg.sv
// Shared types, constants and codes for the best-candidate blue-noise block.
// No dependencies; bcbn_ctrl, bcbn_dp and the top module import this package.
`timescale 1ns / 1ps

package bcbn_pkg;

  // Sample store and occupancy bitmap geometry
  localparam int SAMPLE_SLOTS = 256;
  localparam int SLOT_AW      = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
  localparam int COUNT_W      = 9;
  localparam int GRID_SIZE    = 64;
  localparam int GRID_BITS    = $clog2(GRID_SIZE);

  // Round bookkeeping widths
  localparam int FACTOR_W = 5;
  localparam int POS_W    = 12;
  localparam int LEN_W    = 14;

  // Fixed-point constants (u0.16 coordinates)
  localparam logic [15:0]         HALF_UNIT  = 16'h8000;
  localparam logic [31:0]         FAR_AWAY   = 32'hFFFF_FFFF;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 5'd16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

  // Reset values of the configuration registers
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd8;
  localparam logic [COUNT_W-1:0]  TARGET_RESET = 9'd256;

  // Request kinds
  localparam logic KIND_CAND  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] cand_x;
    logic [15:0] cand_y;
    logic [8:0]  pix_col;
    logic [8:0]  pix_row;
  } req_t;

  typedef struct packed {
    logic        committed;
    logic [15:0] sample_x;
    logic [15:0] sample_y;
    logic        lit;
    logic        full_res;
    logic [8:0]  stored_count;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic scan_issue;
    logic eval;
    logic commit;
    logic map_update;
    logic query_read;
    logic respond;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;
    logic full;
    logic scan_more;
    logic pipe_busy;
    logic round_end;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EVAL,
    ST_COMMIT,
    ST_MAP_WRITE,
    ST_QUERY,
    ST_RESPOND
  } state_t;

endpackage

FILE: design/best_candidate_blue_noise.sv
// A candidate goes through check, scan and round decision, plus commit and bitmap write when
// it ends a round; a query reads the bitmap; a candidate met by a full store just responds.
// Throughput: one request at a time; busy drops in the result cycle, so the next request can
// be taken with it. The scan reads one stored sample per cycle.
// Synchronous reset clears count, round state and bitmap row-valid bits, restores factor 8
// and target 256; done pulses one cycle, no stall. Depends on bcbn_pkg, bcbn_ctrl, bcbn_dp.
`timescale 1ns / 1ps

module best_candidate_blue_noise
  import bcbn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output res_t                  res
);

  cmd_t  cmd;
  stat_t stat;

  // Config writes are taken only while no request is in flight
  assign cfg_ready = !busy;

  bcbn_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  bcbn_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_valid(cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .res      (res)
  );

endmodule

FILE: design/bcbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bcbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bcbn_ctrl.sv
// Controller state machine: sequences scan, round decision, commit and query.
// Depends on bcbn_pkg.
`timescale 1ns / 1ps

module bcbn_ctrl
  import bcbn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.is_query) begin
          state_next = ST_QUERY;
        end else if (stat.full) begin
          state_next = ST_RESPOND;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else if (!stat.pipe_busy) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.round_end ? ST_COMMIT : ST_RESPOND;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_MAP_WRITE;
      end
      ST_MAP_WRITE: begin
        cmd.map_update = 1'b1;
        state_next     = ST_RESPOND;
      end
      ST_QUERY: begin
        cmd.query_read = 1'b1;
        state_next     = ST_RESPOND;
      end
      ST_RESPOND: begin
        cmd.respond = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: design/bcbn_dp.sv
// Datapath: config registers, sample store scan pipeline, round state, bitmap.
// Depends on bcbn_pkg and bcbn_ram.
`timescale 1ns / 1ps

module bcbn_dp
  import bcbn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  done,
  output res_t                  res
);

  // Configuration and round state
  logic [FACTOR_W-1:0] candidate_factor;
  logic [COUNT_W-1:0]  sample_target;
  logic [COUNT_W-1:0]  sample_count;
  logic [POS_W-1:0]    round_position;
  logic [31:0]         best_point;
  logic [31:0]         best_distance;
  logic                commit_flag;
  req_t                req_q;

  // Scan pipeline
  logic [COUNT_W-1:0] scan_idx;
  logic               v0, v1, v2, v3;
  logic [15:0]        gap_x, gap_y;
  logic [31:0]        sq_x, sq_y, dist_sum, min_dist;

  // Memories
  logic [31:0]          store_rdata;
  logic                 map_we, map_re;
  logic [GRID_BITS-1:0] map_raddr;
  logic [GRID_SIZE-1:0] map_wdata, map_rdata;
  logic [GRID_SIZE-1:0] row_valid;

  // Derived values
  logic [FACTOR_W-1:0]  f_eff;
  logic [LEN_W-1:0]     round_len;
  logic [COUNT_W-1:0]   target_eff;
  logic                 is_full;
  logic [POS_W:0]       pos_inc;
  logic                 take_new;
  logic [GRID_BITS-1:0] best_col, best_row, q_col, q_row;
  logic                 lit_val;

  function automatic logic [15:0] axis_gap(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? (a - b) : (b - a);
    if (d > HALF_UNIT) begin
      d = 16'(~d + 16'd1);
    end
    return d;
  endfunction

  // Round length, effective target and decisions
  always_comb begin
    f_eff      = (candidate_factor > FACTOR_MAX) ? FACTOR_MAX : candidate_factor;
    round_len  = LEN_W'(LEN_W'(f_eff) * LEN_W'(sample_count)) + LEN_W'(1);
    target_eff = (sample_target > COUNT_W'(SAMPLE_SLOTS)) ? COUNT_W'(SAMPLE_SLOTS)
                                                         : sample_target;
    is_full    = (sample_count >= target_eff);
    pos_inc    = {1'b0, round_position} + (POS_W + 1)'(1);
    take_new   = (round_position == '0) || (min_dist > best_distance);
    best_col   = best_point[15 -: GRID_BITS];
    best_row   = best_point[31 -: GRID_BITS];
    q_col      = req_q.pix_col[GRID_BITS-1:0];
    q_row      = req_q.pix_row[GRID_BITS-1:0];
    lit_val    = (req_q.kind == KIND_QUERY) && row_valid[q_row] && map_rdata[q_col];
  end

  always_comb begin
    stat.is_query  = (req_q.kind == KIND_QUERY);
    stat.full      = is_full;
    stat.scan_more = (scan_idx < sample_count);
    stat.pipe_busy = v0 | v1 | v2 | v3;
    stat.round_end = (LEN_W'(pos_inc) >= round_len);
  end

  // Sample store
  bcbn_ram #(
    .WIDTH(32),
    .DEPTH(SAMPLE_SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(sample_count[SLOT_AW-1:0]),
    .wdata(best_point),
    .re   (cmd.scan_issue),
    .raddr(scan_idx[SLOT_AW-1:0]),
    .rdata(store_rdata)
  );

  // Occupancy bitmap, one row per word; rows never written read as zero
  assign map_we    = cmd.map_update;
  assign map_re    = cmd.commit | cmd.query_read;
  assign map_raddr = cmd.query_read ? q_row : best_row;
  assign map_wdata = (row_valid[best_row] ? map_rdata : '0) | (GRID_SIZE'(1) << best_col);

  bcbn_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(best_row),
    .wdata(map_wdata),
    .re   (map_re),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req;
    end
  end

  // Scan pipeline: gaps, squares, sum, running minimum
  always_ff @(posedge clk) begin
    gap_x    <= axis_gap(req_q.cand_x, store_rdata[15:0]);
    gap_y    <= axis_gap(req_q.cand_y, store_rdata[31:16]);
    sq_x     <= 32'(gap_x) * 32'(gap_x);
    sq_y     <= 32'(gap_y) * 32'(gap_y);
    dist_sum <= sq_x + sq_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      scan_idx <= '0;
      min_dist <= FAR_AWAY;
    end else begin
      v0 <= cmd.scan_issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      if (cmd.latch) begin
        scan_idx <= '0;
        min_dist <= FAR_AWAY;
      end else begin
        if (cmd.scan_issue) begin
          scan_idx <= scan_idx + COUNT_W'(1);
        end
        if (v3 && (dist_sum < min_dist)) begin
          min_dist <= dist_sum;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_factor <= FACTOR_RESET;
      sample_target    <= TARGET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FACTOR: candidate_factor <= cfg_data[FACTOR_W-1:0];
        CFG_TARGET: sample_target    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Round state, commit and bitmap row bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      round_position <= '0;
      best_point     <= '0;
      best_distance  <= '0;
      commit_flag    <= 1'b0;
      row_valid      <= '0;
    end else begin
      if (cmd.latch) begin
        commit_flag <= 1'b0;
      end
      if (cmd.eval) begin
        if (take_new) begin
          best_point    <= {req_q.cand_y, req_q.cand_x};
          best_distance <= min_dist;
        end
        round_position <= pos_inc[POS_W-1:0];
      end
      if (cmd.map_update) begin
        row_valid[best_row] <= 1'b1;
        sample_count        <= sample_count + COUNT_W'(1);
        round_position      <= '0;
        best_distance       <= '0;
        commit_flag         <= 1'b1;
      end
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      res.committed    <= commit_flag;
      res.sample_x     <= commit_flag ? best_point[15:0] : 16'd0;
      res.sample_y     <= commit_flag ? best_point[31:16] : 16'd0;
      res.lit          <= lit_val;
      res.full_res     <= is_full;
      res.stored_count <= sample_count;
    end
  end

  // Only stored entries are ever read during a scan
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> (scan_idx < sample_count))
    else $error("scan read beyond stored samples");

  // The store never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= COUNT_W'(SAMPLE_SLOTS))
    else $error("sample count above store depth");

  // A commit adds exactly one sample
  a_commit_count: assert property (@(posedge clk) disable iff (rst)
    cmd.map_update |=> (sample_count == $past(sample_count) + COUNT_W'(1)))
    else $error("commit did not advance the count by one");

  // Round decision only after the scan pipeline has drained
  a_eval_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> !(v0 || v1 || v2 || v3))
    else $error("round decision with scan still in flight");

endmodule
